### hw/rtl/mrt_pkg.sv
// Shared types and constants for the mapped region table.
`timescale 1ns / 1ps

package mrt_pkg;

  localparam int NumRegionsDefault = 16;
  localparam int PageShiftDefault  = 12;

  localparam int AddrW  = 38;
  localparam int EndW   = 39;
  localparam int OffW   = 32;
  localparam int PfoW   = 39;
  localparam int ProtW  = 3;
  localparam int SlotW  = 4;
  localparam int StatW  = 3;
  localparam int PermW  = 5;

  localparam int InDataW  = 120;
  localparam int OutDataW = 136;

  // Protection bits of a request.
  localparam int ProtRBit = 0;
  localparam int ProtWBit = 1;
  localparam int ProtXBit = 2;

  // Page table permission bits.
  localparam logic [PermW-1:0] PermU  = 5'h10;
  localparam logic [PermW-1:0] PermR  = 5'h02;
  localparam logic [PermW-1:0] PermWr = 5'h04;
  localparam logic [PermW-1:0] PermX  = 5'h08;

  typedef enum logic [1:0] {
    KIND_MAP    = 2'd0,
    KIND_UNMAP  = 2'd1,
    KIND_LOOKUP = 2'd2,
    KIND_CLEAR  = 2'd3
  } kind_e;

  typedef enum logic [StatW-1:0] {
    ST_OK        = 3'd0,
    ST_NO_FREE   = 3'd1,
    ST_OVERLAP   = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_DENIED    = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_DRAIN
  } state_e;

  // Request token that walks the chain, collecting the first hits.
  typedef struct packed {
    logic             valid;
    kind_e            kind;
    logic [AddrW-1:0] addr;
    logic [EndW-1:0]  addr_end;
    logic [ProtW-1:0] prot;
    logic             has_file;
    logic [OffW-1:0]  map_offset;
    logic             is_write;
    logic             free_found;
    logic [SlotW-1:0] free_slot;
    logic             hit;
    logic [SlotW-1:0] hit_slot;
    logic [AddrW-1:0] m_start;
    logic [EndW-1:0]  m_end;
    logic [ProtW-1:0] m_prot;
    logic             m_file;
    logic [OffW-1:0]  m_offset;
  } tok_t;

  // Write of a new region into the cell that reserved itself.
  typedef struct packed {
    logic             valid;
    logic [AddrW-1:0] start;
    logic [EndW-1:0]  end_addr;
    logic [ProtW-1:0] prot;
    logic             has_file;
    logic [OffW-1:0]  offset;
  } commit_t;

  typedef struct packed {
    logic cand;
  } cell_stat_t;

endpackage

### hw/rtl/mapped_region_table.sv
// Top level of the mapped region table: request entry, cell chain and result stage.
`timescale 1ns / 1ps
// A request is registered at entry, walks the chain of slot cells one cell per cycle,
// waits in the tail register and is then loaded into the output register. Only one
// request is in the table at a time: a new one is taken once the last result is loaded.
// A finished result waits in the output register while the next request walks.
// Reset (rst_ni low, asynchronous) frees every slot and empties the chain.

module mapped_region_table #(
  parameter int NUM_REGIONS = mrt_pkg::NumRegionsDefault,
  parameter int PAGE_SHIFT  = mrt_pkg::PageShiftDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Request side.
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // tdata from bit 0: address[37:0], length[75:38], prot[78:76], has_file[79],
  // map_offset[111:80], is_write[112], zero fill[119:113].
  input  logic [mrt_pkg::InDataW-1:0]   s_axis_tdata,
  // tuser: kind[1:0].
  input  logic [1:0]                    s_axis_tuser,
  // Result side.
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // tdata from bit 0: status[2:0], slot[6:3], region_start[44:7],
  // region_end[83:45], pte_perm[88:84], file_backed[89],
  // page_file_offset[128:90], zero fill[135:129].
  output logic [mrt_pkg::OutDataW-1:0]  m_axis_tdata
);

  localparam int AW = mrt_pkg::AddrW;
  localparam int EW = mrt_pkg::EndW;

  // Clears the byte offset within a page.
  localparam logic [AW-1:0] PageMask = ~((AW'(1) << PAGE_SHIFT) - AW'(1));

  mrt_pkg::state_e state_q, state_d;

  mrt_pkg::tok_t entry_q, entry_d;
  mrt_pkg::tok_t tail_q;
  mrt_pkg::tok_t chain [NUM_REGIONS+1];
  mrt_pkg::cell_stat_t stat [NUM_REGIONS];
  mrt_pkg::commit_t commit;

  logic [NUM_REGIONS:0]   tok_valid;
  logic [NUM_REGIONS-1:0] cand_vec;

  logic in_accept;
  logic tail_load;
  logic out_load;
  logic out_valid_q;

  // Result fields, formed from the token that left the chain.
  mrt_pkg::status_e             res_status;
  logic [mrt_pkg::SlotW-1:0]    res_slot;
  logic [AW-1:0]                res_start;
  logic [EW-1:0]                res_end;
  logic [mrt_pkg::PermW-1:0]    res_perm;
  logic                         res_file;
  logic [mrt_pkg::PfoW-1:0]     res_pfo;
  logic                         res_commit;

  mrt_pkg::status_e             out_status_q;
  logic [mrt_pkg::SlotW-1:0]    out_slot_q;
  logic [AW-1:0]                out_start_q;
  logic [EW-1:0]                out_end_q;
  logic [mrt_pkg::PermW-1:0]    out_perm_q;
  logic                         out_file_q;
  logic [mrt_pkg::PfoW-1:0]     out_pfo_q;

  logic [AW-1:0]                page_addr;

  // The request enters an entry register that also forms the exclusive end
  // of a new region, so no cell has an adder in front of its compares.
  always_comb begin
    entry_d             = '0;
    entry_d.valid       = in_accept;
    entry_d.kind        = mrt_pkg::kind_e'(s_axis_tuser);
    entry_d.addr        = s_axis_tdata[37:0];
    entry_d.addr_end    = {1'b0, s_axis_tdata[37:0]} + {1'b0, s_axis_tdata[75:38]};
    entry_d.prot        = s_axis_tdata[78:76];
    entry_d.has_file    = s_axis_tdata[79];
    entry_d.map_offset  = s_axis_tdata[111:80];
    entry_d.is_write    = s_axis_tdata[112];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q <= '0;
    end else begin
      entry_q <= entry_d;
    end
  end

  assign chain[0] = entry_q;

  // Each cell holds one slot; the token moves one cell per cycle, so the
  // lowest matching slot is always the first to mark the token.
  for (genvar g = 0; g < NUM_REGIONS; g++) begin : g_cell
    mrt_cell #(
      .CellIdx(g)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .tok_i   (chain[g]),
      .commit_i(commit),
      .tok_o   (chain[g+1]),
      .stat_o  (stat[g])
    );
    assign cand_vec[g] = stat[g].cand;
  end

  for (genvar g = 0; g <= NUM_REGIONS; g++) begin : g_valid
    assign tok_valid[g] = chain[g].valid;
  end

  // Sequencer: one request in the chain at a time. A map is only written
  // into its reserved slot after the whole table has been checked for overlap.
  always_comb begin
    state_d       = state_q;
    s_axis_tready = 1'b0;
    tail_load     = 1'b0;
    out_load      = 1'b0;
    unique case (state_q)
      mrt_pkg::S_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          state_d = mrt_pkg::S_WALK;
        end
      end
      mrt_pkg::S_WALK: begin
        if (chain[NUM_REGIONS].valid) begin
          tail_load = 1'b1;
          state_d   = mrt_pkg::S_DRAIN;
        end
      end
      mrt_pkg::S_DRAIN: begin
        if (!out_valid_q || m_axis_tready) begin
          out_load = 1'b1;
          state_d  = mrt_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = mrt_pkg::S_IDLE;
      end
    endcase
  end

  assign in_accept = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mrt_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tail_load) begin
      tail_q <= chain[NUM_REGIONS];
    end
  end

  assign page_addr = tail_q.addr & PageMask;

  // Decide the outcome from what the token collected on its walk.
  always_comb begin
    res_status = mrt_pkg::ST_OK;
    res_slot   = '0;
    res_start  = '0;
    res_end    = '0;
    res_perm   = '0;
    res_file   = 1'b0;
    res_pfo    = '0;
    res_commit = 1'b0;
    unique case (tail_q.kind)
      mrt_pkg::KIND_MAP: begin
        if (!tail_q.free_found) begin
          res_status = mrt_pkg::ST_NO_FREE;
        end else if (tail_q.hit) begin
          res_status = mrt_pkg::ST_OVERLAP;
          res_slot   = tail_q.hit_slot;
        end else begin
          res_slot   = tail_q.free_slot;
          res_commit = 1'b1;
        end
      end
      mrt_pkg::KIND_UNMAP: begin
        if (tail_q.hit) begin
          res_slot = tail_q.hit_slot;
        end else begin
          res_status = mrt_pkg::ST_NOT_FOUND;
        end
      end
      mrt_pkg::KIND_LOOKUP: begin
        if (!tail_q.hit) begin
          res_status = mrt_pkg::ST_NOT_FOUND;
        end else if (tail_q.is_write && !tail_q.m_prot[mrt_pkg::ProtWBit]) begin
          res_status = mrt_pkg::ST_DENIED;
          res_slot   = tail_q.hit_slot;
        end else begin
          res_slot  = tail_q.hit_slot;
          res_start = tail_q.m_start;
          res_end   = tail_q.m_end;
          res_perm  = mrt_pkg::PermU;
          if (tail_q.m_prot[mrt_pkg::ProtRBit]) res_perm = res_perm | mrt_pkg::PermR;
          if (tail_q.m_prot[mrt_pkg::ProtWBit]) res_perm = res_perm | mrt_pkg::PermWr;
          if (tail_q.m_prot[mrt_pkg::ProtXBit]) res_perm = res_perm | mrt_pkg::PermX;
          res_file = tail_q.m_file;
          // The page may lie below an unaligned region start; the
          // difference then wraps, as does the sum.
          if (tail_q.m_file) begin
            res_pfo = {7'b0, tail_q.m_offset} + ({1'b0, page_addr} - {1'b0, tail_q.m_start});
          end
        end
      end
      mrt_pkg::KIND_CLEAR: begin
        res_status = mrt_pkg::ST_OK;
      end
      default: begin
        res_status = mrt_pkg::ST_OK;
      end
    endcase
  end

  assign commit.valid    = out_load && res_commit;
  assign commit.start    = tail_q.addr;
  assign commit.end_addr = tail_q.addr_end;
  assign commit.prot     = tail_q.prot;
  assign commit.has_file = tail_q.has_file;
  assign commit.offset   = tail_q.map_offset;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_status_q <= res_status;
      out_slot_q   <= res_slot;
      out_start_q  <= res_start;
      out_end_q    <= res_end;
      out_perm_q   <= res_perm;
      out_file_q   <= res_file;
      out_pfo_q    <= res_pfo;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'b0, out_pfo_q, out_file_q, out_perm_q, out_end_q,
                          out_start_q, out_slot_q, out_status_q};

  // Only one request is ever in flight along the chain.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(tok_valid) <= 1)
    else $error("more than one request in the cell chain");

  // An idle sequencer means the chain is empty.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == mrt_pkg::S_IDLE |-> tok_valid == '0)
    else $error("request in the chain while idle");

  // A map leaving the chain has a free slot exactly when one cell reserved itself.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    chain[NUM_REGIONS].valid && chain[NUM_REGIONS].kind == mrt_pkg::KIND_MAP
    |-> chain[NUM_REGIONS].free_found == (|cand_vec))
    else $error("free slot flag disagrees with slot reservation");

  // A region write lands in exactly one slot.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit.valid |-> $onehot(cand_vec))
    else $error("region write without a single reserved slot");

endmodule

### hw/rtl/mrt_cell.sv
// One slot of the region table and its stage of the request chain.
`timescale 1ns / 1ps

module mrt_cell #(
  parameter int CellIdx = 0
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  mrt_pkg::tok_t        tok_i,
  input  mrt_pkg::commit_t     commit_i,
  output mrt_pkg::tok_t        tok_o,
  output mrt_pkg::cell_stat_t  stat_o
);

  localparam logic [mrt_pkg::SlotW-1:0] SlotId = mrt_pkg::SlotW'(CellIdx);

  logic                        used_q, used_d;
  logic                        cand_q, cand_d;
  mrt_pkg::tok_t               tok_q, tok_d;
  logic [mrt_pkg::AddrW-1:0]   start_q;
  logic [mrt_pkg::EndW-1:0]    end_q;
  logic [mrt_pkg::ProtW-1:0]   prot_q;
  logic                        file_q;
  logic [mrt_pkg::OffW-1:0]    offset_q;

  logic [mrt_pkg::EndW-1:0]    addr_x;
  logic                        overlap;
  logic                        covers;

  assign addr_x  = {1'b0, tok_i.addr};
  assign overlap = (addr_x < end_q) && (tok_i.addr_end > {1'b0, start_q});
  assign covers  = (tok_i.addr >= start_q) && (addr_x < end_q);

  always_comb begin
    tok_d  = tok_i;
    used_d = used_q;
    cand_d = cand_q;
    if (tok_i.valid) begin
      cand_d = 1'b0;
      unique case (tok_i.kind)
        mrt_pkg::KIND_MAP: begin
          if (!used_q && !tok_i.free_found) begin
            tok_d.free_found = 1'b1;
            tok_d.free_slot  = SlotId;
            cand_d           = 1'b1;
          end
          if (used_q && overlap && !tok_i.hit) begin
            tok_d.hit      = 1'b1;
            tok_d.hit_slot = SlotId;
          end
        end
        mrt_pkg::KIND_UNMAP: begin
          if (used_q && (start_q == tok_i.addr) && !tok_i.hit) begin
            used_d         = 1'b0;
            tok_d.hit      = 1'b1;
            tok_d.hit_slot = SlotId;
          end
        end
        mrt_pkg::KIND_LOOKUP: begin
          if (used_q && covers && !tok_i.hit) begin
            tok_d.hit      = 1'b1;
            tok_d.hit_slot = SlotId;
            tok_d.m_start  = start_q;
            tok_d.m_end    = end_q;
            tok_d.m_prot   = prot_q;
            tok_d.m_file   = file_q;
            tok_d.m_offset = offset_q;
          end
        end
        mrt_pkg::KIND_CLEAR: begin
          used_d = 1'b0;
        end
        default: begin
          used_d = used_q;
        end
      endcase
    end else if (commit_i.valid && cand_q) begin
      used_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= 1'b0;
      cand_q <= 1'b0;
      tok_q  <= '0;
    end else begin
      used_q <= used_d;
      cand_q <= cand_d;
      tok_q  <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit_i.valid && cand_q) begin
      start_q  <= commit_i.start;
      end_q    <= commit_i.end_addr;
      prot_q   <= commit_i.prot;
      file_q   <= commit_i.has_file;
      offset_q <= commit_i.offset;
    end
  end

  assign tok_o       = tok_q;
  assign stat_o.cand = cand_q;

endmodule

### tb/mrt_result_checker.sv
// Result checker for the mapped region table: predicts each answer and compares it.
`timescale 1ns / 1ps

module mrt_result_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  input  logic                          s_axis_tready,
  input  logic [mrt_pkg::InDataW-1:0]   s_axis_tdata,
  input  logic [1:0]                    s_axis_tuser,
  input  logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  input  logic [mrt_pkg::OutDataW-1:0]  m_axis_tdata,
  output int                            err_cnt,
  output int                            pending_cnt,
  output int                            n_ok,
  output int                            n_no_free,
  output int                            n_overlap,
  output int                            n_not_found,
  output int                            n_denied
);

  localparam int NumSlots  = mrt_pkg::NumRegionsDefault;
  localparam int PageShift = mrt_pkg::PageShiftDefault;

  localparam logic [4:0] PTE_U = 5'h10;
  localparam logic [4:0] PTE_R = 5'h02;
  localparam logic [4:0] PTE_W = 5'h04;
  localparam logic [4:0] PTE_X = 5'h08;

  typedef struct packed {
    mrt_pkg::status_e                status;
    logic [mrt_pkg::SlotW-1:0]       slot;
    logic [mrt_pkg::AddrW-1:0]       region_start;
    logic [mrt_pkg::EndW-1:0]        region_end;
    logic [4:0]                      perm;
    logic                            file_backed;
    logic [mrt_pkg::PfoW-1:0]        pfo;
  } region_answer_t;

  // Shadow copy of the region table.
  logic                        tbl_used  [NumSlots];
  logic [mrt_pkg::AddrW-1:0]   tbl_start [NumSlots];
  logic [mrt_pkg::AddrW-1:0]   tbl_len   [NumSlots];
  logic [mrt_pkg::ProtW-1:0]   tbl_prot  [NumSlots];
  logic                        tbl_file  [NumSlots];
  logic [mrt_pkg::OffW-1:0]    tbl_off   [NumSlots];

  region_answer_t answers_due[$];
  region_answer_t want;
  region_answer_t got;

  // Applies one request to the shadow table and returns the answer it must produce.
  function automatic region_answer_t apply_request(
    input mrt_pkg::kind_e              kind,
    input logic [mrt_pkg::AddrW-1:0]   addr,
    input logic [mrt_pkg::AddrW-1:0]   len,
    input logic [mrt_pkg::ProtW-1:0]   prot,
    input logic                        has_file,
    input logic [mrt_pkg::OffW-1:0]    foff,
    input logic                        is_write
  );
    region_answer_t a;
    int free_idx;
    int hit_idx;
    logic [mrt_pkg::EndW-1:0]  req_end;
    logic [mrt_pkg::EndW-1:0]  reg_end;
    logic [mrt_pkg::AddrW-1:0] page;
    a = '0;
    a.status = mrt_pkg::ST_OK;
    free_idx = -1;
    hit_idx = -1;
    req_end = {1'b0, addr} + {1'b0, len};
    case (kind)
      mrt_pkg::KIND_MAP: begin
        for (int i = 0; i < NumSlots; i++)
          if (free_idx < 0 && !tbl_used[i]) free_idx = i;
        if (free_idx < 0) begin
          a.status = mrt_pkg::ST_NO_FREE;
        end else begin
          for (int i = 0; i < NumSlots; i++) begin
            reg_end = {1'b0, tbl_start[i]} + {1'b0, tbl_len[i]};
            if (hit_idx < 0 && tbl_used[i] && {1'b0, addr} < reg_end &&
                req_end > {1'b0, tbl_start[i]})
              hit_idx = i;
          end
          if (hit_idx >= 0) begin
            a.status = mrt_pkg::ST_OVERLAP;
            a.slot = mrt_pkg::SlotW'(hit_idx);
          end else begin
            tbl_used[free_idx]  = 1'b1;
            tbl_start[free_idx] = addr;
            tbl_len[free_idx]   = len;
            tbl_prot[free_idx]  = prot;
            tbl_file[free_idx]  = has_file;
            tbl_off[free_idx]   = foff;
            a.slot = mrt_pkg::SlotW'(free_idx);
          end
        end
      end
      mrt_pkg::KIND_UNMAP: begin
        for (int i = 0; i < NumSlots; i++)
          if (hit_idx < 0 && tbl_used[i] && tbl_start[i] == addr) hit_idx = i;
        if (hit_idx < 0) begin
          a.status = mrt_pkg::ST_NOT_FOUND;
        end else begin
          tbl_used[hit_idx] = 1'b0;
          a.slot = mrt_pkg::SlotW'(hit_idx);
        end
      end
      mrt_pkg::KIND_LOOKUP: begin
        for (int i = 0; i < NumSlots; i++) begin
          reg_end = {1'b0, tbl_start[i]} + {1'b0, tbl_len[i]};
          if (hit_idx < 0 && tbl_used[i] && addr >= tbl_start[i] && {1'b0, addr} < reg_end)
            hit_idx = i;
        end
        if (hit_idx < 0) begin
          a.status = mrt_pkg::ST_NOT_FOUND;
        end else begin
          a.slot = mrt_pkg::SlotW'(hit_idx);
          if (is_write && !tbl_prot[hit_idx][mrt_pkg::ProtWBit]) begin
            a.status = mrt_pkg::ST_DENIED;
          end else begin
            page = addr & ~((mrt_pkg::AddrW'(1) << PageShift) - mrt_pkg::AddrW'(1));
            a.region_start = tbl_start[hit_idx];
            a.region_end = {1'b0, tbl_start[hit_idx]} + {1'b0, tbl_len[hit_idx]};
            a.perm = PTE_U;
            if (tbl_prot[hit_idx][mrt_pkg::ProtRBit]) a.perm = a.perm | PTE_R;
            if (tbl_prot[hit_idx][mrt_pkg::ProtWBit]) a.perm = a.perm | PTE_W;
            if (tbl_prot[hit_idx][mrt_pkg::ProtXBit]) a.perm = a.perm | PTE_X;
            a.file_backed = tbl_file[hit_idx];
            // The page may start below an unaligned region; the difference wraps.
            if (tbl_file[hit_idx])
              a.pfo = {7'd0, tbl_off[hit_idx]} + ({1'b0, page} - {1'b0, tbl_start[hit_idx]});
          end
        end
      end
      default: begin
        for (int i = 0; i < NumSlots; i++) tbl_used[i] = 1'b0;
      end
    endcase
    return a;
  endfunction

  task automatic check_field(input string name, input logic [63:0] seen, input logic [63:0] due);
    if (seen !== due) begin
      $display("%0t: %s mismatch, got 0x%0h, expected 0x%0h", $time, name, seen, due);
      err_cnt++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumSlots; i++) tbl_used[i] = 1'b0;
      answers_due.delete();
      err_cnt = 0;
      pending_cnt = 0;
      n_ok = 0;
      n_no_free = 0;
      n_overlap = 0;
      n_not_found = 0;
      n_denied = 0;
    end else begin
      // Results are taken before requests so an answer never meets its own request.
      if (m_axis_tvalid && m_axis_tready) begin
        got.status       = mrt_pkg::status_e'(m_axis_tdata[2:0]);
        got.slot         = m_axis_tdata[6:3];
        got.region_start = m_axis_tdata[44:7];
        got.region_end   = m_axis_tdata[83:45];
        got.perm         = m_axis_tdata[88:84];
        got.file_backed  = m_axis_tdata[89];
        got.pfo          = m_axis_tdata[128:90];
        if (answers_due.size() == 0) begin
          $display("%0t: result with status %0d arrived with no request waiting",
                   $time, got.status);
          err_cnt++;
        end else begin
          want = answers_due.pop_front();
          check_field("status", 64'(got.status), 64'(want.status));
          check_field("slot", 64'(got.slot), 64'(want.slot));
          check_field("region_start", 64'(got.region_start), 64'(want.region_start));
          check_field("region_end", 64'(got.region_end), 64'(want.region_end));
          check_field("pte_perm", 64'(got.perm), 64'(want.perm));
          check_field("file_backed", 64'(got.file_backed), 64'(want.file_backed));
          check_field("page_file_offset", 64'(got.pfo), 64'(want.pfo));
        end
        case (got.status)
          mrt_pkg::ST_OK:        n_ok++;
          mrt_pkg::ST_NO_FREE:   n_no_free++;
          mrt_pkg::ST_OVERLAP:   n_overlap++;
          mrt_pkg::ST_NOT_FOUND: n_not_found++;
          default:               n_denied++;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready)
        answers_due.push_back(apply_request(mrt_pkg::kind_e'(s_axis_tuser),
                                            s_axis_tdata[37:0], s_axis_tdata[75:38],
                                            s_axis_tdata[78:76], s_axis_tdata[79],
                                            s_axis_tdata[111:80], s_axis_tdata[112]));
      pending_cnt = answers_due.size();
    end
  end

endmodule

### tb/tb_mapped_region_table.sv
// Testbench top for the mapped region table: clock, reset, request stimulus and verdict.
`timescale 1ns / 1ps

module tb_mapped_region_table;

  localparam int NumReq        = 550;
  localparam int NumSlots      = mrt_pkg::NumRegionsDefault;
  // The drain wait lasts as long as two requests take to pass through the table.
  localparam int DrainCycles   = 2 * (NumSlots + 3);
  localparam int HoldOffCycles = 200;
  // Longest quiet stretch is the receiver hold-off plus a walk; allow far more.
  localparam int StallLimit    = 3000;

  localparam logic [37:0] LowZone  = 38'h0;
  localparam logic [37:0] HighZone = 38'h3F_FFF0_0000;

  logic                         clk_i;
  logic                         rst_ni = 1'b0;
  logic                         s_axis_tvalid = 1'b0;
  logic                         s_axis_tready;
  logic [mrt_pkg::InDataW-1:0]  s_axis_tdata = '0;
  logic [1:0]                   s_axis_tuser = '0;
  logic                         m_axis_tvalid;
  logic                         m_axis_tready = 1'b0;
  logic [mrt_pkg::OutDataW-1:0] m_axis_tdata;

  int err_cnt, pending_cnt;
  int n_ok, n_no_free, n_overlap, n_not_found, n_denied;

  // Idle percentages for both sides, and the one long hold-off on the result side.
  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  logic hold_off_req  = 1'b0;
  logic hold_off_done = 1'b0;
  int   hold_left     = 0;
  int   quiet_cycles  = 0;
  int   sent_cnt      = 0;

  // Recently mapped regions, so lookups and unmaps aim at live entries.
  logic [37:0] seen_start [8];
  logic [37:0] seen_len   [8];
  int          seen_wr  = 0;
  int          seen_num = 0;

  mapped_region_table u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  mrt_result_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .err_cnt       (err_cnt),
    .pending_cnt   (pending_cnt),
    .n_ok          (n_ok),
    .n_no_free     (n_no_free),
    .n_overlap     (n_overlap),
    .n_not_found   (n_not_found),
    .n_denied      (n_denied)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // The result side idles at random, except during the single long hold-off, which
  // backs the table up until it stops taking requests.
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else if (hold_off_req && !hold_off_done) begin
      hold_left <= HoldOffCycles;
      hold_off_done <= 1'b1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // The watchdog ends a run in which nothing moves on either side for too long.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("Watchdog: nothing moved for %0d cycles, %0d results still due",
               StallLimit, pending_cnt);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [37:0] rand38();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[37:0];
  endfunction

  // Region starts mostly fall in two small windows, at the bottom and at the top of the
  // address space, so that overlaps and hits are common; a few land anywhere.
  function automatic logic [37:0] zone_addr();
    logic [37:0] off;
    if ($urandom_range(9) == 0) return rand38();
    off = 38'($urandom_range(255)) << 9;
    if ($urandom_range(1)) off = off + 38'($urandom_range(511));
    return ($urandom_range(1) ? HighZone : LowZone) + off;
  endfunction

  function automatic logic [37:0] rand_len();
    int r;
    r = $urandom_range(99);
    if (r < 5) return 38'd0;
    if (r < 10) return rand38();
    return 38'($urandom_range(16'h3000, 1));
  endfunction

  // Aims at a recently mapped region: mostly inside it, sometimes just below or past it.
  function automatic logic [37:0] probe_addr();
    int idx;
    if (seen_num == 0) return zone_addr();
    idx = $urandom_range(seen_num - 1);
    if ($urandom_range(7) == 0) return seen_start[idx] - 38'($urandom_range(64, 1));
    return seen_start[idx] + 38'($urandom_range(16'h3400));
  endfunction

  // Offers one request and returns once it has been accepted.
  task automatic send_req(input mrt_pkg::kind_e kind, input logic [37:0] addr,
                          input logic [37:0] len, input logic [2:0] prot,
                          input logic has_file, input logic [31:0] foff,
                          input logic is_write);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'd0, is_write, foff, has_file, prot, len, addr};
    s_axis_tuser  <= kind;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sent_cnt++;
    if (kind == mrt_pkg::KIND_MAP) begin
      seen_start[seen_wr] = addr;
      seen_len[seen_wr] = len;
      seen_wr = (seen_wr + 1) % 8;
      if (seen_num < 8) seen_num++;
    end
  endtask

  task automatic map_req(input logic [37:0] addr, input logic [37:0] len,
                         input logic [2:0] prot, input logic has_file,
                         input logic [31:0] foff);
    send_req(mrt_pkg::KIND_MAP, addr, len, prot, has_file, foff, 1'b0);
  endtask

  // The unused fields of non-map requests carry random bits; the table must ignore them.
  task automatic lookup_req(input logic [37:0] addr, input logic is_write);
    send_req(mrt_pkg::KIND_LOOKUP, addr, rand38(), 3'($urandom), 1'($urandom), $urandom,
             is_write);
  endtask

  task automatic unmap_req(input logic [37:0] addr);
    send_req(mrt_pkg::KIND_UNMAP, addr, rand38(), 3'($urandom), 1'($urandom), $urandom,
             1'($urandom));
  endtask

  task automatic clear_req();
    send_req(mrt_pkg::KIND_CLEAR, rand38(), rand38(), 3'($urandom), 1'($urandom), $urandom,
             1'($urandom));
  endtask

  initial begin
    logic [37:0] reg_a;
    logic [37:0] reg_b;
    logic [37:0] base;
    int          r;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed requests: edges of the fields and each corner of the table rules.
    reg_a = 38'h0_0123_4567;
    reg_b = 38'h20_0000_0000;
    send_idle_pct = 23;
    recv_idle_pct = 50;
    clear_req();
    map_req(reg_a, 38'h3000, 3'b001, 1'b1, 32'hFFFF_FFF0);
    lookup_req(reg_a + 38'h10, 1'b0);           // page starts below the unaligned region
    lookup_req(reg_a + 38'h20, 1'b1);           // write to a read-only region
    map_req(reg_a + 38'h1000, 38'h100, 3'b111, 1'b0, 32'h0);   // overlaps the first region
    map_req(38'h0, 38'h0, 3'b000, 1'b0, 32'h0);                // zero length region
    lookup_req(38'h0, 1'b0);                    // a zero length region contains nothing
    map_req({38{1'b1}}, {38{1'b1}}, 3'b111, 1'b0, 32'h0);      // highest start and length
    lookup_req({38{1'b1}}, 1'b1);               // writable and not backed by a file
    map_req(38'h0, {38{1'b1}}, 3'b010, 1'b1, 32'h0);           // spans almost everything
    unmap_req(38'h5555);                        // unmap of an address never mapped
    unmap_req(reg_a);
    lookup_req(reg_a, 1'b0);                    // lookup after the unmap misses
    map_req(reg_b, 38'h1_0000, 3'b011, 1'b1, 32'h0000_1234);
    lookup_req(reg_b + 38'h5678, 1'b1);
    unmap_req(38'h0);
    clear_req();
    lookup_req({38{1'b1}}, 1'b0);               // the table is empty after a clear

    // Random sequences until the request budget is used up.
    while (sent_cnt < NumReq) begin
      if (sent_cnt < NumReq / 3) begin
        send_idle_pct = 23;
        recv_idle_pct = 50;
      end else if (sent_cnt < 2 * NumReq / 3) begin
        send_idle_pct = 50;
        recv_idle_pct = 23;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (sent_cnt >= 120) hold_off_req <= 1'b1;

      r = $urandom_range(99);
      if (r < 35) begin
        // Map a region, probe it, and sometimes take it away again.
        base = zone_addr();
        map_req(base, rand_len(), 3'($urandom), 1'($urandom), $urandom);
        repeat ($urandom_range(3, 1)) lookup_req(probe_addr(), 1'($urandom));
        if ($urandom_range(1)) unmap_req(base);
      end else if (r < 38) begin
        // Fill the whole table with disjoint regions, then overflow it.
        clear_req();
        base = zone_addr() & ~38'hFFF;
        for (int k = 0; k < NumSlots + 2; k++)
          map_req(base + 38'(k) * 38'h2000, 38'($urandom_range(16'h2000, 1)),
                  3'($urandom), 1'($urandom), $urandom);
        repeat (3) lookup_req(base + 38'($urandom_range(NumSlots * 16'h2000)),
                              1'($urandom));
        unmap_req(base + 38'($urandom_range(NumSlots - 1)) * 38'h2000);
        map_req(zone_addr(), rand_len(), 3'($urandom), 1'($urandom), $urandom);
      end else if (r < 68) begin
        case ($urandom_range(2))
          0: map_req(probe_addr(), rand_len(), 3'($urandom), 1'($urandom), $urandom);
          1: lookup_req(probe_addr(), 1'($urandom));
          default: unmap_req(seen_num > 0 ? seen_start[$urandom_range(seen_num - 1)]
                                           : zone_addr());
        endcase
      end else if (r < 84) begin
        lookup_req(probe_addr(), 1'($urandom));
        if (seen_num > 0) unmap_req(seen_start[$urandom_range(seen_num - 1)]);
      end else if (r < 96) begin
        // Noise: every field random.
        send_req(mrt_pkg::kind_e'($urandom_range(3)), rand38(), rand38(), 3'($urandom),
                 1'($urandom), $urandom, 1'($urandom));
      end else begin
        clear_req();
      end
    end
    s_axis_tvalid <= 1'b0;

    // Let every outstanding answer arrive, then watch a little longer for strays.
    @(negedge clk_i);
    wait (pending_cnt == 0);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Sent %0d requests (map, unmap, lookup, clear, full table and random noise).",
             sent_cnt);
    $display("Answers seen: %0d ok, %0d table full, %0d overlap, %0d miss, %0d denied.",
             n_ok, n_no_free, n_overlap, n_not_found, n_denied);
    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

### mapped_region_table.f
hw/rtl/mrt_pkg.sv
hw/rtl/mrt_cell.sv
hw/rtl/mapped_region_table.sv
tb/mrt_result_checker.sv
tb/tb_mapped_region_table.sv
